@@ sv/assert_macros.svh @@
// Assertion macros used by the decoder unit. Every use expects signals named
// clk and arst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// A property that must hold at every clock edge out of reset.
`define LZWFB_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("lzwfb assertion failed");

// A same-cycle implication.
`define LZWFB_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lzwfb implication failed");

`else

`define LZWFB_ASSERT(lbl, prop)
`define LZWFB_ASSERT_IMPL(lbl, ante, cons)

`endif

`endif

@@ sv/lzwfb_pkg.sv @@
`default_nettype none

package lzwfb_pkg;

	localparam int TABLE_SIZE       = 256;
	localparam int IDX_W            = $clog2(TABLE_SIZE);
	localparam int CODE_W           = IDX_W + 1;
	localparam int DEPTH_W          = IDX_W + 1;
	localparam int BYTES_PER_RESULT = 8;
	localparam int OUT_W            = 64;
	localparam int CNT_W            = 4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [OUT_W-1:0] out_bytes;
		logic [CNT_W-1:0] byte_count;
		logic             end_of_code;
		logic             chain_error;
	} out_item_t;

	// Accesses to the prefix and suffix tables.
	typedef struct packed {
		logic              pfx_we;
		logic [IDX_W-1:0]  pfx_waddr;
		logic [CODE_W-1:0] pfx_wdata;
		logic [IDX_W-1:0]  pfx_raddr;
		logic              sfx_we;
		logic [IDX_W-1:0]  sfx_waddr;
		logic [7:0]        sfx_wdata;
		logic [IDX_W-1:0]  sfx_raddr;
	} dict_req_t;

	// Accesses to the reversal stack.
	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		logic [7:0]       wdata;
		logic [IDX_W-1:0] raddr;
	} stack_req_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_EMIT,
		ST_ERR
	} state_t;

endpackage

`default_nettype wire

@@ sv/lzwfb_chan_if.sv @@
`default_nettype none

interface lzwfb_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ sv/lzwfb_dict.sv @@
`default_nettype none

module lzwfb_dict import lzwfb_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire dict_req_t         req,
	output logic                   ready,
	output logic [CODE_W-1:0]      pfx_rdata,
	output logic [7:0]             sfx_rdata
);

	logic [CODE_W-1:0] pfx_mem [TABLE_SIZE];
	logic [7:0]        sfx_mem [TABLE_SIZE];
	logic [IDX_W:0]    clr_q;

	// After reset both tables are swept to zero, one entry per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (!clr_q[IDX_W]) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	assign ready = clr_q[IDX_W];

	always_ff @(posedge clk) begin
		if (!clr_q[IDX_W]) begin
			pfx_mem[clr_q[IDX_W-1:0]] <= '0;
		end else if (req.pfx_we) begin
			pfx_mem[req.pfx_waddr] <= req.pfx_wdata;
		end
		pfx_rdata <= pfx_mem[req.pfx_raddr];
	end

	always_ff @(posedge clk) begin
		if (!clr_q[IDX_W]) begin
			sfx_mem[clr_q[IDX_W-1:0]] <= '0;
		end else if (req.sfx_we) begin
			sfx_mem[req.sfx_waddr] <= req.sfx_wdata;
		end
		sfx_rdata <= sfx_mem[req.sfx_raddr];
	end

endmodule

`default_nettype wire

@@ sv/lzwfb_stack.sv @@
`default_nettype none

module lzwfb_stack import lzwfb_pkg::*; (
	input  wire logic       clk,
	input  wire stack_req_t req,
	output logic [7:0]      rdata
);

	logic [7:0] mem [TABLE_SIZE];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rdata <= mem[req.raddr];
	end

endmodule

`default_nettype wire

@@ sv/lzw_flag_byte_code_decoder_unit.sv @@
// Flag byte: accepted, no result. Code byte with a chain of d steps: accepted,
// then a prefix walk (one table read per step), then one byte per cycle (d of
// them) fetched through the stack and suffix read ports while the result has
// room, packed into results of up to eight bytes. A literal code gives one byte.
// One item at a time; a result still held by the receiver stalls the next result.
// After reset the tables are swept to zero before the first request is accepted.
`default_nettype none
`include "assert_macros.svh"

module lzw_flag_byte_code_decoder_unit import lzwfb_pkg::*; #(
	parameter int RESULT_BYTES = BYTES_PER_RESULT
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	lzwfb_chan_if.sink     bytes_chan,
	lzwfb_chan_if.source   result_chan
);

	state_t state_q, state_d;

	logic [7:0]         flag_bits_q;
	logic [2:0]         flag_pos_q;
	logic               await_q;
	logic [IDX_W-1:0]   ne_q;
	logic               last_q;
	logic [CODE_W-1:0]  w_q;
	logic               sel_rd_q;
	logic [DEPTH_W-1:0] depth_q;
	logic [OUT_W-1:0]   pack_q;
	logic [CNT_W-1:0]   pack_cnt_q;
	logic [DEPTH_W-1:0] base_q;
	logic [DEPTH_W-1:0] k_issue_q;
	logic               fetch_v_s1;
	logic               fetch_v_s2;
	logic               out_valid_q;
	out_item_t          out_q;

	in_item_t           in_item;
	logic               dict_ready;
	logic [CODE_W-1:0]  pfx_rdata;
	logic [7:0]         sfx_rdata;
	logic [7:0]         stk_rdata;
	dict_req_t          dict_req;
	stack_req_t         stk_req;

	logic               accept_in;
	logic               accept_code;
	logic [CODE_W-1:0]  wcur;
	logic               walk_push;
	logic               walk_err;
	logic               walk_end;
	logic [DEPTH_W-1:0] total;
	logic [DEPTH_W-1:0] done_cnt;
	logic [DEPTH_W-1:0] stk_off;
	logic [DEPTH_W:0]   chunk_end;
	logic               can_issue;
	logic               out_free;
	logic               all_done;
	logic               flush;
	logic               flush_end;
	logic               err_load;
	logic               finish;

	assign in_item = bytes_chan.payload;

	lzwfb_dict u_dict (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (dict_req),
		.ready     (dict_ready),
		.pfx_rdata (pfx_rdata),
		.sfx_rdata (sfx_rdata)
	);

	lzwfb_stack u_stack (
		.clk   (clk),
		.req   (stk_req),
		.rdata (stk_rdata)
	);

	// The first walk step uses the code itself; later steps use the prefix just read.
	assign wcur      = sel_rd_q ? pfx_rdata : w_q;
	assign total     = depth_q + 1'b1;
	assign done_cnt  = base_q + DEPTH_W'(pack_cnt_q);
	assign stk_off   = depth_q - k_issue_q;
	assign chunk_end = {1'b0, base_q} + (DEPTH_W+1)'(RESULT_BYTES);
	assign out_free  = !out_valid_q || result_chan.ready;
	assign all_done  = (done_cnt == total);

	always_comb begin
		accept_in   = bytes_chan.valid && bytes_chan.ready;
		accept_code = accept_in && !await_q;
		walk_push   = (state_q == ST_WALK) && wcur[IDX_W]
			&& (depth_q != DEPTH_W'(TABLE_SIZE));
		walk_err    = (state_q == ST_WALK) && wcur[IDX_W]
			&& (depth_q == DEPTH_W'(TABLE_SIZE));
		walk_end    = (state_q == ST_WALK) && !wcur[IDX_W];
		// Reads are issued only as far as the current result has room, so a
		// byte in flight always fits into the pack.
		can_issue   = (state_q == ST_EMIT) && (k_issue_q < total)
			&& ({1'b0, k_issue_q} < chunk_end);
		flush       = (state_q == ST_EMIT) && out_free
			&& ((pack_cnt_q == CNT_W'(RESULT_BYTES)) || all_done);
		flush_end   = flush && all_done;
		err_load    = (state_q == ST_ERR) && out_free;
		finish      = flush_end || err_load;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (accept_code) state_d = ST_WALK;
			ST_WALK: begin
				if (walk_err) begin
					state_d = ST_ERR;
				end else if (walk_end) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: if (flush_end) state_d = ST_IDLE;
			ST_ERR:  if (err_load) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		bytes_chan.ready    = (state_q == ST_IDLE) && dict_ready;
		result_chan.valid   = out_valid_q;
		result_chan.payload = out_q;

		dict_req.pfx_we    = accept_code;
		dict_req.pfx_waddr = ne_q;
		dict_req.pfx_wdata = {flag_bits_q[7], in_item.data_byte};
		dict_req.pfx_raddr = wcur[IDX_W-1:0];
		dict_req.sfx_we    = walk_end && (ne_q != '0);
		dict_req.sfx_waddr = ne_q - 1'b1;
		dict_req.sfx_wdata = wcur[7:0];
		dict_req.sfx_raddr = stk_rdata;

		stk_req.we    = walk_push;
		stk_req.waddr = depth_q[IDX_W-1:0];
		stk_req.wdata = wcur[IDX_W-1:0];
		stk_req.raddr = stk_off[IDX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			flag_bits_q <= '0;
			flag_pos_q  <= '0;
			await_q     <= 1'b1;
			ne_q        <= '0;
			last_q      <= 1'b0;
			w_q         <= '0;
			sel_rd_q    <= 1'b0;
			depth_q     <= '0;
			pack_cnt_q  <= '0;
			base_q      <= '0;
			k_issue_q   <= '0;
			fetch_v_s1  <= 1'b0;
			fetch_v_s2  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (accept_in && await_q) begin
				if (in_item.last_byte) begin
					flag_bits_q <= '0;
					ne_q        <= '0;
				end else begin
					flag_bits_q <= in_item.data_byte;
					await_q     <= 1'b0;
				end
				flag_pos_q <= '0;
			end else if (accept_code) begin
				flag_bits_q <= {flag_bits_q[6:0], 1'b0};
				if (flag_pos_q == 3'd7) begin
					flag_pos_q <= '0;
					await_q    <= 1'b1;
				end else begin
					flag_pos_q <= flag_pos_q + 1'b1;
				end
				last_q   <= in_item.last_byte;
				w_q      <= {flag_bits_q[7], in_item.data_byte};
				sel_rd_q <= 1'b0;
				depth_q  <= '0;
			end

			if (walk_push) begin
				depth_q  <= depth_q + 1'b1;
				sel_rd_q <= 1'b1;
			end

			if (walk_end) begin
				ne_q       <= ne_q + 1'b1;
				pack_cnt_q <= CNT_W'(1);
				base_q     <= '0;
				k_issue_q  <= DEPTH_W'(1);
				fetch_v_s1 <= 1'b0;
				fetch_v_s2 <= 1'b0;
			end else if (state_q == ST_EMIT) begin
				fetch_v_s1 <= can_issue;
				fetch_v_s2 <= fetch_v_s1;
				if (can_issue) begin
					k_issue_q <= k_issue_q + 1'b1;
				end
				if (flush) begin
					pack_cnt_q <= '0;
					base_q     <= done_cnt;
				end else if (fetch_v_s2) begin
					pack_cnt_q <= pack_cnt_q + 1'b1;
				end
			end

			if (flush || err_load) begin
				out_valid_q <= 1'b1;
			end else if (result_chan.ready) begin
				out_valid_q <= 1'b0;
			end

			// End of stream: the next byte is a flag byte again.
			if (finish && last_q) begin
				await_q     <= 1'b1;
				flag_bits_q <= '0;
				flag_pos_q  <= '0;
				ne_q        <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (walk_end) begin
			pack_q <= OUT_W'(wcur[7:0]);
		end else if (flush) begin
			pack_q <= '0;
		end else if (fetch_v_s2) begin
			pack_q[{pack_cnt_q[2:0], 3'b000} +: 8] <= sfx_rdata;
		end

		if (flush) begin
			out_q.out_bytes   <= pack_q;
			out_q.byte_count  <= pack_cnt_q;
			out_q.end_of_code <= all_done;
			out_q.chain_error <= 1'b0;
		end else if (err_load) begin
			out_q.out_bytes   <= '0;
			out_q.byte_count  <= '0;
			out_q.end_of_code <= 1'b1;
			out_q.chain_error <= 1'b1;
		end
	end

	`LZWFB_ASSERT_IMPL(a_pack_room, fetch_v_s2, pack_cnt_q < CNT_W'(RESULT_BYTES))
	`LZWFB_ASSERT_IMPL(a_issue_bound, state_q == ST_EMIT, k_issue_q <= total)
	`LZWFB_ASSERT_IMPL(a_err_empty, out_valid_q && out_q.chain_error, (out_q.byte_count == '0) && out_q.end_of_code && (out_q.out_bytes == '0))
	`LZWFB_ASSERT(a_depth_range, depth_q <= DEPTH_W'(TABLE_SIZE))

endmodule

`default_nettype wire
